/* sv/rle_span_encoder_macros.svh */
// Assertion macros for the run-length span encoder.
`ifndef RLE_SPAN_ENCODER_MACROS_SVH
`define RLE_SPAN_ENCODER_MACROS_SVH

`ifndef NO_ASSERTIONS
// Same-cycle implication, clocked on clk, off during reset.
`define RSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Next-cycle implication, clocked on clk, off during reset.
`define RSE_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) pre |=> post) else $error(msg);
`else
`define RSE_ASSERT(lbl, prop, msg)
`define RSE_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

/* sv/rse_pkg.sv */
// Shared constants and types of the run-length span encoder.
package rse_pkg;

  localparam int MAX_SPAN    = 127;
  localparam int CHUNK_BYTES = 16384;
  localparam int WORD_BYTES  = 8;

  localparam int CFG_W       = 15;
  localparam int LEN_W       = 7;
  localparam int QDEPTH      = 4;
  localparam int QPTR_W      = 2;
  localparam int OUT_TDATA_W = 72;

  localparam logic [1:0] KIND_LIT   = 2'd0;
  localparam logic [1:0] KIND_REP   = 2'd1;
  localparam logic [1:0] KIND_ABORT = 2'd2;

  localparam logic [7:0] REP_FLAG = 8'h80;

  // One closed span, handed from front to back.
  typedef struct packed {
    logic [1:0]       kind;
    logic [LEN_W-1:0] len;
    logic [7:0]       head;
    logic             bank;
    logic             last;
  } span_cmd_t;

  // Literal store write, front to back.
  typedef struct packed {
    logic             en;
    logic             bank;
    logic [LEN_W-1:0] idx;
    logic [7:0]       data;
  } lit_wr_t;

  // Literal bank handed back to the front once drained.
  typedef struct packed {
    logic en;
    logic bank;
  } bank_rel_t;

endpackage

/* sv/rse_front.sv */
// Front end: span detection, size check and span command generation.
module rse_front (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [rse_pkg::CFG_W-1:0] chunk_length,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [7:0]                in_byte,
  input  logic                      in_end,
  output logic                      push,
  output rse_pkg::span_cmd_t        push_cmd,
  input  logic                      q_full,
  output rse_pkg::lit_wr_t          lit_wr,
  input  rse_pkg::bank_rel_t        bank_rel
);
  import rse_pkg::*;

  logic [LEN_W-1:0] span_len, span_len_next;
  logic             is_rep, is_rep_next;
  logic [7:0]       prev_byte, prev_byte_next;
  logic [7:0]       head_byte, head_byte_next;
  logic [CFG_W-1:0] enc_count, enc_count_next;
  logic [CFG_W-1:0] in_count, in_count_next;
  logic             aborted, aborted_next;
  logic             flush, flush_next;
  logic             wbank, wbank_next;
  logic [1:0]       bank_busy, bank_busy_next;

  logic [CFG_W-1:0] limit;
  logic [CFG_W:0]   close_sum;
  logic             close_abort;
  logic             close_rep;
  logic             close_uses_bank;
  logic [CFG_W-1:0] close_add;
  logic             acc;
  logic             final_byte;

  // Effective limit: zero reads as one, large values saturate.
  always_comb begin
    if (chunk_length == '0) begin
      limit = CFG_W'(1);
    end else if (chunk_length > CFG_W'(CHUNK_BYTES)) begin
      limit = CFG_W'(CHUNK_BYTES);
    end else begin
      limit = chunk_length;
    end
  end

  // Closing the open span; the full length counts, for repeats too.
  assign close_sum       = {1'b0, enc_count} + (CFG_W+1)'(1) + (CFG_W+1)'(span_len);
  assign close_abort     = close_sum >= {1'b0, limit};
  assign close_rep       = is_rep && (span_len >= LEN_W'(2));
  assign close_uses_bank = !close_rep && (span_len >= LEN_W'(2));
  assign close_add       = close_rep ? CFG_W'(2) : CFG_W'(1) + CFG_W'(span_len);

  always_comb begin
    push_cmd.kind = close_abort ? KIND_ABORT : (close_rep ? KIND_REP : KIND_LIT);
    push_cmd.len  = span_len;
    push_cmd.head = head_byte;
    push_cmd.bank = wbank;
    push_cmd.last = flush;
  end

  assign in_ready   = !flush && !q_full && !bank_busy[wbank];
  assign acc        = in_valid && in_ready;
  assign final_byte = in_end || (({1'b0, in_count} + (CFG_W+1)'(1)) >= {1'b0, limit});

  always_comb begin
    span_len_next  = span_len;
    is_rep_next    = is_rep;
    prev_byte_next = prev_byte;
    head_byte_next = head_byte;
    enc_count_next = enc_count;
    in_count_next  = in_count;
    aborted_next   = aborted;
    flush_next     = flush;
    wbank_next     = wbank;
    bank_busy_next = bank_busy;
    push           = 1'b0;
    lit_wr.en      = 1'b0;
    lit_wr.bank    = wbank;
    lit_wr.idx     = span_len;
    lit_wr.data    = in_byte;

    if (bank_rel.en) begin
      bank_busy_next[bank_rel.bank] = 1'b0;
    end

    if (flush) begin
      // End of chunk: flush the open span, then return to the chunk start.
      if (!q_full) begin
        if (!aborted && (span_len != '0)) begin
          push = 1'b1;
          if (!close_abort && close_uses_bank) begin
            bank_busy_next[wbank] = 1'b1;
            wbank_next            = ~wbank;
          end
        end
        span_len_next  = '0;
        is_rep_next    = 1'b0;
        prev_byte_next = '0;
        enc_count_next = '0;
        in_count_next  = '0;
        aborted_next   = 1'b0;
        flush_next     = 1'b0;
      end
    end else if (acc) begin
      in_count_next = in_count + CFG_W'(1);
      flush_next    = final_byte;
      if (!aborted) begin
        prev_byte_next = in_byte;
        if (span_len == '0) begin
          head_byte_next = in_byte;
          span_len_next  = LEN_W'(1);
          is_rep_next    = 1'b0;
        end else if (span_len == LEN_W'(1)) begin
          is_rep_next   = (in_byte == prev_byte);
          lit_wr.en     = (in_byte != prev_byte);
          span_len_next = LEN_W'(2);
        end else if (is_rep && (in_byte == prev_byte) && (span_len < LEN_W'(MAX_SPAN))) begin
          span_len_next = span_len + LEN_W'(1);
        end else if (!is_rep && (in_byte != prev_byte) &&
                     (span_len < LEN_W'(MAX_SPAN))) begin
          lit_wr.en     = 1'b1;
          span_len_next = span_len + LEN_W'(1);
        end else begin
          // Span breaks: close it and, unless it aborts, open a new one on this byte.
          push = 1'b1;
          if (close_abort) begin
            aborted_next  = 1'b1;
            span_len_next = '0;
            is_rep_next   = 1'b0;
          end else begin
            enc_count_next = enc_count + close_add;
            if (close_uses_bank) begin
              bank_busy_next[wbank] = 1'b1;
              wbank_next            = ~wbank;
            end
            head_byte_next = in_byte;
            span_len_next  = LEN_W'(1);
            is_rep_next    = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      span_len  <= '0;
      is_rep    <= 1'b0;
      prev_byte <= '0;
      enc_count <= '0;
      in_count  <= '0;
      aborted   <= 1'b0;
      flush     <= 1'b0;
      wbank     <= 1'b0;
      bank_busy <= '0;
    end else begin
      span_len  <= span_len_next;
      is_rep    <= is_rep_next;
      prev_byte <= prev_byte_next;
      enc_count <= enc_count_next;
      in_count  <= in_count_next;
      aborted   <= aborted_next;
      flush     <= flush_next;
      wbank     <= wbank_next;
      bank_busy <= bank_busy_next;
    end
  end

  always_ff @(posedge clk) begin
    head_byte <= head_byte_next;
  end

endmodule

/* sv/rse_queue.sv */
// Span command queue between front and back.
module rse_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push,
  input  rse_pkg::span_cmd_t push_cmd,
  output logic               full,
  input  logic               pop,
  output rse_pkg::span_cmd_t head,
  output logic               empty
);
  import rse_pkg::*;

  span_cmd_t         slots [QDEPTH];
  logic [QPTR_W-1:0] wptr;
  logic [QPTR_W-1:0] rptr;
  logic [QPTR_W:0]   count;

  assign full  = count == (QPTR_W+1)'(QDEPTH);
  assign empty = count == '0;
  assign head  = slots[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= wptr + QPTR_W'(1);
      end
      if (pop) begin
        rptr <= rptr + QPTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + (QPTR_W+1)'(1);
      end else if (pop && !push) begin
        count <= count - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wptr] <= push_cmd;
    end
  end

endmodule

/* sv/rse_back.sv */
// Back end: literal store, span byte emission and word packing.
module rse_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               q_empty,
  input  rse_pkg::span_cmd_t q_head,
  output logic               pop,
  input  rse_pkg::lit_wr_t   lit_wr,
  output rse_pkg::bank_rel_t bank_rel,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [63:0]        out_word,
  output logic [3:0]         out_count,
  output logic               out_last,
  output logic               out_big
);
  import rse_pkg::*;

  // Two banks of literal bytes; index 0 is never used (head byte rides in the command).
  logic [7:0] lit_mem [2**(LEN_W+1)];
  logic [7:0] rd_data;
  logic [LEN_W:0] rd_addr;

  logic                       busy;
  span_cmd_t                  cur;
  logic [LEN_W-1:0]           pos;
  logic [8*WORD_BYTES-1:0]    acc_word;
  logic [2:0]                 acc_n;

  logic [LEN_W:0]   cnt;
  logic             last_byte;
  logic             is_abort;
  logic [7:0]       cur_byte;
  logic             emit;
  logic             slot_free;
  logic             adv;
  logic [63:0]      word_full;
  logic [LEN_W-1:0] np;
  logic [LEN_W-1:0] rd_idx;

  assign cnt       = (cur.kind == KIND_REP) ? (LEN_W+1)'(2) : (LEN_W+1)'(cur.len) + (LEN_W+1)'(1);
  assign last_byte = {1'b0, pos} == (cnt - (LEN_W+1)'(1));
  assign is_abort  = cur.kind == KIND_ABORT;

  always_comb begin
    case (pos)
      LEN_W'(0): begin
        cur_byte = (cur.kind == KIND_REP) ? (REP_FLAG | {1'b0, cur.len}) : {1'b0, cur.len};
      end
      LEN_W'(1): begin
        cur_byte = cur.head;
      end
      default: begin
        cur_byte = rd_data;
      end
    endcase
  end

  assign emit      = busy && (is_abort || (acc_n == 3'(WORD_BYTES-1)) || last_byte);
  assign slot_free = !out_valid || out_ready;
  assign adv       = busy && (!emit || slot_free);
  assign pop       = !busy && !q_empty;

  // Lanes below acc_n come from the accumulator, lane acc_n takes the current byte, lanes above stay zero.
  always_comb begin
    word_full = '0;
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (3'(i) < acc_n) begin
        word_full[i*8 +: 8] = acc_word[i*8 +: 8];
      end else if (3'(i) == acc_n) begin
        word_full[i*8 +: 8] = cur_byte;
      end
    end
  end

  // Prefetch: address the byte that will be needed next cycle.
  assign np     = adv ? pos + LEN_W'(1) : pos;
  assign rd_idx = (np < LEN_W'(2)) ? LEN_W'(1) : np - LEN_W'(1);
  assign rd_addr = busy ? {cur.bank, rd_idx} : {q_head.bank, LEN_W'(1)};

  assign bank_rel.en   = adv && last_byte && (cur.kind == KIND_LIT) && (cur.len >= LEN_W'(2));
  assign bank_rel.bank = cur.bank;

  always_ff @(posedge clk) begin
    if (lit_wr.en) begin
      lit_mem[{lit_wr.bank, lit_wr.idx}] <= lit_wr.data;
    end
    rd_data <= lit_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      acc_n     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (pop) begin
        busy  <= 1'b1;
        acc_n <= '0;
      end else if (adv) begin
        if (emit) begin
          acc_n <= '0;
          if (last_byte || is_abort) begin
            busy <= 1'b0;
          end
        end else begin
          acc_n <= acc_n + 3'(1);
        end
      end
      if (adv && emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_head;
      pos <= '0;
    end else if (adv) begin
      pos      <= pos + LEN_W'(1);
      acc_word <= word_full;
    end
    if (adv && emit) begin
      out_word  <= is_abort ? '0 : word_full;
      out_count <= is_abort ? '0 : {1'b0, acc_n} + 4'(1);
      out_last  <= is_abort || (cur.last && last_byte);
      out_big   <= is_abort;
    end
  end

endmodule

/* sv/rle_span_encoder.sv */
// Run-length span encoder: top level with configuration register and stream ports.
// Flow: a span enters the span queue at the edge that takes the byte breaking it, or
//   in the flush state after the last byte of a chunk; with the back idle it is popped
//   and its encoded bytes are packed into words for m_tdata, one byte per cycle while the output is taken.
// Throughput: 1 byte per cycle in the front, with no byte taken in the flush state after the last
//   byte of a chunk; the back drains 1 encoded byte per cycle while its output is taken, with a
//   pop between spans; the front waits on a full span queue or on a literal bank still being read.
// Reset: synchronous on rst; clears all control, chunk_length returns to 16384;
//   literal store contents are left as they are.
`include "rle_span_encoder_macros.svh"

module rle_span_encoder (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration: chunk_length
  input  logic                            cfg_we,
  input  logic [rse_pkg::CFG_W-1:0]       cfg_wdata,
  // Input stream
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,  // [7:0] data_byte
  input  logic                            s_tlast,  // chunk_end
  // Output stream
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [rse_pkg::OUT_TDATA_W-1:0] m_tdata,  // [63:0] out_word, [67:64] out_count
  output logic                            m_tlast,  // out_last
  output logic                            m_tuser   // too_big
);
  import rse_pkg::*;

  logic [CFG_W-1:0] chunk_length;

  logic       q_push;
  span_cmd_t  q_push_cmd;
  logic       q_full;
  logic       q_pop;
  span_cmd_t  q_head;
  logic       q_empty;
  lit_wr_t    lit_wr;
  bank_rel_t  bank_rel;

  logic [63:0] out_word;
  logic [3:0]  out_count;
  logic        too_big;

  // Bytes per chunk and size limit; it must be written only while idle, which the block leaves to the user.
  always_ff @(posedge clk) begin
    if (rst) begin
      chunk_length <= CFG_W'(CHUNK_BYTES);
    end else if (cfg_we) begin
      chunk_length <= cfg_wdata;
    end
  end

  // Front: span detection, abort decision, span commands into the queue.
  rse_front u_front (
    .clk          (clk),
    .rst          (rst),
    .chunk_length (chunk_length),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .in_byte      (s_tdata),
    .in_end       (s_tlast),
    .push         (q_push),
    .push_cmd     (q_push_cmd),
    .q_full       (q_full),
    .lit_wr       (lit_wr),
    .bank_rel     (bank_rel)
  );

  // Short command queue lets the front keep scanning while spans drain.
  rse_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // Back: expands spans to bytes and packs them into 64-bit words.
  rse_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_empty   (q_empty),
    .q_head    (q_head),
    .pop       (q_pop),
    .lit_wr    (lit_wr),
    .bank_rel  (bank_rel),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word),
    .out_count (out_count),
    .out_last  (m_tlast),
    .out_big   (too_big)
  );

  assign m_tdata = {(OUT_TDATA_W-68)'(0), out_count, out_word};
  assign m_tuser = too_big;

  // An abort transaction is empty and closes the chunk.
  `RSE_ASSERT(a_abort_form, m_tvalid && too_big |-> m_tlast && (out_count == '0) && (out_word == '0), "abort result malformed")
  // Regular transactions carry one to eight bytes.
  `RSE_ASSERT(a_count_range, m_tvalid && !too_big |-> (out_count != '0) && (out_count <= 4'(WORD_BYTES)), "byte count out of range")
  // The front never pushes into a full queue.
  `RSE_ASSERT(a_no_push_full, q_push |-> !q_full, "push into full span queue")
  // The chunk flush cycle follows the last byte, with no byte taken.
  `RSE_ASSERT_NEXT(a_flush_stall, s_tvalid && s_tready && s_tlast, !s_tready, "byte taken during chunk flush")

endmodule

/* bench/rle_span_encoder_tb.sv */
// Self-checking bench for rle_span_encoder: raw bytes in, packed span words checked out.
`timescale 1ns / 100ps

module rle_span_encoder_tb;
  import rse_pkg::*;

  localparam int DRAIN_CYCLES = 24;   // covers span queue plus a 16-word literal drain
  localparam int STALL_CYCLES = 400;  // long receiver hold-off, block must back-pressure

  typedef struct packed {
    logic [7:0] data;
    logic       chunk_end;
  } raw_byte_t;

  typedef struct packed {
    logic [63:0] word;
    logic [3:0]  nbytes;
    logic        last;
    logic        big;
  } enc_word_t;

  logic                   clk       = 1'b0;
  logic                   rst       = 1'b1;
  logic                   cfg_we    = 1'b0;
  logic [CFG_W-1:0]       cfg_wdata = '0;
  logic                   s_tvalid  = 1'b0;
  logic                   s_tready;
  logic [7:0]             s_tdata   = '0;
  logic                   s_tlast   = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready  = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;
  logic                   m_tlast;
  logic                   m_tuser;

  raw_byte_t feed_q[$];      // bytes waiting to be offered
  enc_word_t enc_exp_q[$];   // encoded words still owed by the block
  int n_queued    = 0;
  int n_sent      = 0;
  int n_errors    = 0;
  int tx_idle_pct = 7;
  int rx_idle_pct = 70;
  logic stall_go   = 1'b0;
  int   stall_left = 0;

  // Encoder shadow state
  logic [CFG_W-1:0] enc_chunk_len = CFG_W'(CHUNK_BYTES);
  logic [7:0]       enc_lit [0:127];
  int               enc_span_len = 0;
  bit               enc_is_rep   = 1'b0;
  logic [7:0]       enc_prev     = '0;
  int               enc_out_cnt  = 0;
  int               enc_in_cnt   = 0;
  bit               enc_aborted  = 1'b0;

  rle_span_encoder u_dut (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  task automatic flag_mismatch(input string msg);
    n_errors++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  // Effective chunk length: zero reads as one, large values clamp.
  function automatic int size_limit();
    int c;
    c = int'(enc_chunk_len);
    if (c == 0) c = 1;
    if (c > CHUNK_BYTES) c = CHUNK_BYTES;
    return c;
  endfunction

  task automatic start_span(input logic [7:0] b);
    enc_lit[0]   = b;
    enc_span_len = 1;
    enc_is_rep   = 1'b0;
  endtask

  // Close the open span: either the abort marker or the header+payload in words.
  task automatic flush_span(input bit last);
    logic [7:0]  enc [0:129];
    logic [63:0] w;
    int          len, cnt, k;
    bit          rep;
    if (enc_aborted || enc_span_len == 0) return;
    len          = enc_span_len;
    rep          = enc_is_rep && len >= 2;
    enc_span_len = 0;
    enc_is_rep   = 1'b0;
    if (enc_out_cnt + 1 + len >= size_limit()) begin
      enc_aborted = 1'b1;
      enc_exp_q.push_back('{word: '0, nbytes: '0, last: 1'b1, big: 1'b1});
      return;
    end
    if (rep) begin
      enc[0] = REP_FLAG | 8'(len);
      enc[1] = enc_prev;
      cnt    = 2;
    end else begin
      enc[0] = 8'(len);
      for (int i = 0; i < len; i++) enc[1+i] = enc_lit[i];
      cnt = 1 + len;
    end
    enc_out_cnt += cnt;
    for (int pos = 0; pos < cnt; pos += WORD_BYTES) begin
      k = (cnt - pos > WORD_BYTES) ? WORD_BYTES : cnt - pos;
      w = '0;
      for (int i = 0; i < k; i++) w[8*i +: 8] = enc[pos+i];
      enc_exp_q.push_back('{word: w, nbytes: 4'(k), last: last && (pos + k >= cnt),
                            big: 1'b0});
    end
  endtask

  // One accepted byte through the greedy span splitter.
  task automatic encode_byte(input logic [7:0] b, input logic endf);
    bit final_byte;
    enc_in_cnt++;
    final_byte = endf || enc_in_cnt >= size_limit();
    if (!enc_aborted) begin
      if (enc_span_len == 0) begin
        start_span(b);
      end else if (enc_span_len == 1) begin
        if (b == enc_prev) begin
          enc_is_rep = 1'b1;
        end else begin
          enc_lit[1] = b;
          enc_is_rep = 1'b0;
        end
        enc_span_len = 2;
      end else if (enc_is_rep) begin
        if (b == enc_prev && enc_span_len < MAX_SPAN) begin
          enc_span_len++;
        end else begin
          flush_span(1'b0);
          if (!enc_aborted) start_span(b);
        end
      end else begin
        if (b != enc_prev && enc_span_len < MAX_SPAN) begin
          enc_lit[enc_span_len] = b;
          enc_span_len++;
        end else begin
          flush_span(1'b0);
          if (!enc_aborted) start_span(b);
        end
      end
      enc_prev = b;
      if (final_byte && !enc_aborted) flush_span(1'b1);
    end
    if (final_byte) begin
      enc_span_len = 0;
      enc_is_rep   = 1'b0;
      enc_prev     = '0;
      enc_out_cnt  = 0;
      enc_in_cnt   = 0;
      enc_aborted  = 1'b0;
    end
  endtask

  // Sender: holds a byte until taken, then predicts on the accepting edge.
  always @(posedge clk) begin : drv
    raw_byte_t nxt;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        encode_byte(s_tdata, s_tlast);
        n_sent++;
      end
      if (feed_q.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        nxt = feed_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata  <= nxt.data;
        s_tlast  <= nxt.chunk_end;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Long receiver hold-off, counted here once kicked off.
  always @(posedge clk) begin
    if (rst) begin
      stall_left <= 0;
    end else if (stall_go) begin
      stall_left <= STALL_CYCLES;
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Output monitor: every transaction against the oldest owed word.
  always @(posedge clk) begin : mon
    enc_word_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (enc_exp_q.size() == 0) begin
        flag_mismatch($sformatf("unexpected word %h last %b big %b",
                                m_tdata, m_tlast, m_tuser));
      end else begin
        want = enc_exp_q.pop_front();
        if (m_tdata[63:0] !== want.word)
          flag_mismatch($sformatf("out_word %h, want %h", m_tdata[63:0], want.word));
        if (m_tdata[67:64] !== want.nbytes)
          flag_mismatch($sformatf("out_count %0d, want %0d", m_tdata[67:64], want.nbytes));
        if (m_tlast !== want.last)
          flag_mismatch($sformatf("out_last %b, want %b", m_tlast, want.last));
        if (m_tuser !== want.big)
          flag_mismatch($sformatf("too_big %b, want %b", m_tuser, want.big));
      end
    end
  end

  task automatic push_byte(input logic [7:0] b, input logic endf);
    feed_q.push_back('{data: b, chunk_end: endf});
    n_queued++;
  endtask

  // style 0: runs and literal stretches, 1: random bytes, 2: two-symbol noise,
  // 3: pure literal (no byte equals its predecessor). Last byte carries tlast.
  task automatic push_chunk(input int nbytes, input int style);
    logic [7:0] prev, b;
    int         run, left, i;
    bit         as_run;
    left = nbytes;
    prev = 8'($urandom);
    while (left > 0) begin
      as_run = 1'b0;
      case (style)
        0: begin
          as_run = 1'($urandom_range(1));
          if (as_run)
            run = ($urandom_range(7) == 0) ? $urandom_range(120, 140) : $urandom_range(2, 9);
          else
            run = ($urandom_range(7) == 0) ? $urandom_range(120, 135) : $urandom_range(1, 12);
        end
        3:       run = left;
        default: run = 1;
      endcase
      b = 8'($urandom);
      for (i = 0; i < run && left > 0; i++) begin
        if (!as_run) begin
          if (style == 2) b = $urandom_range(1) ? 8'hFF : 8'h00;
          else b = 8'($urandom);
          if ((style == 0 || style == 3) && b == prev) b = b + 8'd1;
        end
        push_byte(b, left == 1);
        prev = b;
        left--;
      end
    end
  endtask

  // Sender pause: everything offered taken, everything owed delivered, then drain.
  task automatic settle();
    while (n_sent != n_queued || enc_exp_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_chunk_len(input logic [CFG_W-1:0] v);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we        <= 1'b0;
    enc_chunk_len  = v;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed, reset chunk length: one-byte chunks, short repeat, literal
    // closed by a repeat, repeat then lone byte, two-byte literal, 9-byte encoding.
    tx_idle_pct = 7;
    rx_idle_pct = 70;
    push_byte(8'h00, 1'b1);
    push_byte(8'hFF, 1'b1);
    push_byte(8'hAA, 1'b0); push_byte(8'hAA, 1'b0); push_byte(8'hAA, 1'b1);
    push_byte(8'h01, 1'b0); push_byte(8'h02, 1'b0); push_byte(8'h03, 1'b0);
    push_byte(8'h03, 1'b0); push_byte(8'h03, 1'b1);
    push_byte(8'h05, 1'b0); push_byte(8'h05, 1'b0); push_byte(8'h07, 1'b1);
    push_byte(8'h80, 1'b0); push_byte(8'h7F, 1'b1);
    push_byte(8'h12, 1'b0); push_byte(8'h34, 1'b0); push_byte(8'h56, 1'b0);
    push_byte(8'h78, 1'b0); push_byte(8'h9A, 1'b0); push_byte(8'hBC, 1'b0);
    push_byte(8'hDE, 1'b0); push_byte(8'hF0, 1'b1);
    settle();

    // Zero length reads as one: every byte is a chunk and aborts.
    write_chunk_len('0);
    repeat (6) push_byte(8'($urandom), 1'($urandom_range(1)));
    settle();

    write_chunk_len(CFG_W'(1));
    repeat (4) push_byte(8'($urandom), 1'($urandom_range(1)));
    settle();

    // Above the maximum: clamps to the full chunk size.
    write_chunk_len('1);
    push_chunk(16, 0);
    settle();

    tx_idle_pct = 70;
    rx_idle_pct = 7;
    // Short chunks end on the count as well as on tlast; aborts are common.
    write_chunk_len(CFG_W'(24));
    push_chunk(25, 1);
    push_chunk(12, 2);
    settle();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    // Receiver holds off while the sender keeps pushing a full literal span
    // (16 words plus a flushed single byte) and a repeat run past MAX_SPAN.
    write_chunk_len(CFG_W'(CHUNK_BYTES));
    stall_go <= 1'b1;
    push_chunk(128, 3);
    for (int i = 0; i < 130; i++) push_byte(8'h3C, i == 129);
    @(posedge clk);
    stall_go <= 1'b0;
    settle();

    write_chunk_len(CFG_W'(3));
    push_byte(8'h11, 1'b1);
    push_byte(8'h22, 1'b0); push_byte(8'h22, 1'b0); push_byte(8'h33, 1'b0);
    push_byte(8'h44, 1'b1);
    push_byte(8'h55, 1'b1);
    settle();

    if (enc_exp_q.size() != 0)
      flag_mismatch($sformatf("%0d words never arrived", enc_exp_q.size()));
    if (n_errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

/* files.f */
+incdir+sv
sv/rse_pkg.sv
sv/rse_front.sv
sv/rse_queue.sv
sv/rse_back.sv
sv/rle_span_encoder.sv
bench/rle_span_encoder_tb.sv
